// ===== src/ahc_pkg.sv =====
// Package for the absolute humidity converter: field widths, fixed-point constants
// and the record types that travel alongside the pipeline.
// Depends on nothing; ahc_exp2 and the converter unit import it, ahc_divider does not.
package ahc_pkg;

    localparam int H_W = 14;
    localparam int C_W = 15;
    localparam int OUT_W = 16;
    localparam int N_W = 8;
    localparam int EXP_TERMS = 9;

    localparam logic [18:0] MAGNUS_NUM = 19'd491520;
    localparam logic signed [16:0] MAGNUS_DEN = 17'sd23770;
    localparam logic [31:0] LOG2_10_Q30 = 32'd3566893132;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [13:0] VP_SCALE = 14'd12220;
    localparam logic signed [16:0] KELVIN_OFS = 17'sd27300;
    localparam logic [9:0] GAS_SCALE = 10'd923;

    // Reciprocals floor(2^32 / k) for the series term divisions, with k = 1 saturated to 2^32 - 1.
    localparam logic [31:0] RECIP_Q32 [1:EXP_TERMS] = '{
        32'd4294967295, 32'd2147483648, 32'd1431655765, 32'd1073741824,
        32'd858993459, 32'd715827882, 32'd613566756, 32'd536870912,
        32'd477218588
    };

    typedef logic [15:0] frac_t;
    typedef logic [29:0] lnarg_t;
    typedef logic [30:0] term_t;
    typedef logic [31:0] sum_t;

    typedef struct packed {
        logic [H_W-1:0]        h;
        logic signed [C_W-1:0] c;
    } env_t;

    typedef struct packed {
        logic neg;
        env_t env;
    } div_side_t;

    typedef struct packed {
        logic signed [N_W-1:0] n;
        env_t                  env;
    } exp_side_t;

endpackage

// ===== src/ahc_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; carries a side record alongside each transaction.
module ahc_divider #(
    parameter int NW = 33,
    parameter int DW = 16,
    parameter int QW = 21,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quot,
    output logic [DW-1:0] rem,
    output logic [SW-1:0] side_out
);

    logic          st_vld  [0:QW];
    logic [DW-1:0] st_rem  [0:QW];
    logic [QW-1:0] st_num  [0:QW];
    logic [QW-1:0] st_quot [0:QW];
    logic [DW-1:0] st_den  [0:QW];
    logic [SW-1:0] st_side [0:QW];

    assign st_vld[0]  = in_valid;
    assign st_rem[0]  = DW'(numer >> QW);
    assign st_num[0]  = numer[QW-1:0];
    assign st_quot[0] = '0;
    assign st_den[0]  = denom;
    assign st_side[0] = side_in;

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic          vld_reg;
        logic [DW-1:0] rem_reg;
        logic [QW-1:0] num_reg;
        logic [QW-1:0] quot_reg;
        logic [DW-1:0] den_reg;
        logic [SW-1:0] side_reg;
        logic [DW:0]   trial;
        logic          fits;
        logic [DW-1:0] rem_next;

        assign trial = {st_rem[i], st_num[i][QW-1]};
        assign fits = (trial >= {1'b0, st_den[i]});
        assign rem_next = fits ? DW'(trial - {1'b0, st_den[i]}) : DW'(trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= st_vld[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg  <= rem_next;
            num_reg  <= QW'(st_num[i] << 1);
            quot_reg <= {st_quot[i][QW-2:0], fits};
            den_reg  <= st_den[i];
            side_reg <= st_side[i];
        end

        assign st_vld[i+1]  = vld_reg;
        assign st_rem[i+1]  = rem_reg;
        assign st_num[i+1]  = num_reg;
        assign st_quot[i+1] = quot_reg;
        assign st_den[i+1]  = den_reg;
        assign st_side[i+1] = side_reg;
    end

    assign out_valid = st_vld[QW];
    assign quot      = st_quot[QW];
    assign rem       = st_rem[QW];
    assign side_out  = st_side[QW];

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (st_rem[QW] < st_den[QW]))
        else $error("divider remainder not below divisor");

endmodule

// ===== src/ahc_exp2.sv =====
// Pipelined 2^f evaluator for a Q16 fraction, as a Taylor series up to order nine in Q30.
// Depends on ahc_pkg for the constants and the reciprocal table.
module ahc_exp2
    import ahc_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  frac_t         frac,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output sum_t          pow2,
    output logic [SW-1:0] side_out
);

    logic          t0_vld_reg;
    lnarg_t        t_reg;
    logic [SW-1:0] t0_side_reg;
    lnarg_t        t_next;

    logic          k_vld  [0:EXP_TERMS];
    lnarg_t        k_t    [0:EXP_TERMS];
    term_t         k_term [0:EXP_TERMS];
    sum_t          k_sum  [0:EXP_TERMS];
    logic [SW-1:0] k_side [0:EXP_TERMS];

    assign t_next = lnarg_t'((46'(frac) * 46'(LN2_Q30)) >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_vld_reg <= 1'b0;
        end
        else
        begin
            t0_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        t0_side_reg <= side_in;
    end

    assign k_vld[0]  = t0_vld_reg;
    assign k_t[0]    = t_reg;
    assign k_term[0] = ONE_Q30;
    assign k_sum[0]  = sum_t'(ONE_Q30);
    assign k_side[0] = t0_side_reg;

    for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
        logic          a_vld_reg, b_vld_reg, c_vld_reg;
        term_t         a_v_reg, b_v_reg, b_q_reg, c_term_reg;
        lnarg_t        a_t_reg, b_t_reg, c_t_reg;
        sum_t          a_sum_reg, b_sum_reg, c_sum_reg;
        logic [SW-1:0] a_side_reg, b_side_reg, c_side_reg;
        term_t         a_v_next, b_q_next, c_term_next;
        logic [34:0]   diff;

        assign a_v_next = term_t'((61'(k_term[k-1]) * 61'(k_t[k-1])) >> 30);
        assign b_q_next = term_t'((63'(a_v_reg) * 63'(RECIP_Q32[k])) >> 32);
        assign diff = 35'(b_v_reg) - 35'(b_q_reg) * 35'(k);
        assign c_term_next = b_q_reg + term_t'(diff >= 35'(k));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_vld_reg <= 1'b0;
                b_vld_reg <= 1'b0;
                c_vld_reg <= 1'b0;
            end
            else
            begin
                a_vld_reg <= k_vld[k-1];
                b_vld_reg <= a_vld_reg;
                c_vld_reg <= b_vld_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            a_v_reg    <= a_v_next;
            a_t_reg    <= k_t[k-1];
            a_sum_reg  <= k_sum[k-1];
            a_side_reg <= k_side[k-1];
            b_v_reg    <= a_v_reg;
            b_q_reg    <= b_q_next;
            b_t_reg    <= a_t_reg;
            b_sum_reg  <= a_sum_reg;
            b_side_reg <= a_side_reg;
            c_term_reg <= c_term_next;
            c_t_reg    <= b_t_reg;
            c_sum_reg  <= b_sum_reg + sum_t'(c_term_next);
            c_side_reg <= b_side_reg;
        end

        assign k_vld[k]  = c_vld_reg;
        assign k_t[k]    = c_t_reg;
        assign k_term[k] = c_term_reg;
        assign k_sum[k]  = c_sum_reg;
        assign k_side[k] = c_side_reg;
    end

    assign out_valid = k_vld[EXP_TERMS];
    assign pow2      = k_sum[EXP_TERMS];
    assign side_out  = k_side[EXP_TERMS];

    a_pow2_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pow2 >= sum_t'(ONE_Q30)) && (pow2 < (sum_t'(ONE_Q30) << 1)))
        else $error("series result outside one to two");

endmodule

// ===== src/absolute_humidity_converter_unit.sv =====
// Absolute humidity converter: relative humidity and temperature in, grams of water per
// cubic meter out in unsigned fixed point, clamped with a flag. The block is a fixed
// pipeline of 97 register stages that takes one transaction in every clock cycle, so busy
// is always low. Results cannot be held off: each one is valid only in the single cycle in
// which done is high. The depth is set by the two restoring dividers (21 and 40 stages)
// and the power series up to order nine (28 stages).
// Depends on ahc_pkg, ahc_divider and ahc_exp2.
module absolute_humidity_converter_unit
    import ahc_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [H_W-1:0]        rel_humidity,
    input  logic signed [C_W-1:0] temperature,
    output logic                  done,
    output logic [OUT_W-1:0]      abs_humidity,
    output logic                  saturated
);

    localparam int RND_SHIFT = 24 - FRAC_BITS;
    localparam logic [40:0] RND_HALF = 41'(1) << (RND_SHIFT - 1);
    localparam int LATENCY = 97;

    logic                  in_vld_reg;
    logic [H_W-1:0]        h_reg;
    logic signed [C_W-1:0] c_reg;

    logic                  s1_vld_reg;
    logic [32:0]           s1_num_reg;
    logic [15:0]           s1_den_reg;
    div_side_t             s1_side_reg;
    logic [C_W-1:0]        cmag;
    logic signed [16:0]    den1_sum;

    logic                  d1_vld;
    logic [20:0]           d1_quot;
    logic [15:0]           d1_rem;
    div_side_t             d1_side;

    logic                  s2_vld_reg;
    logic signed [21:0]    x_reg;
    env_t                  s2_env_reg;
    logic [21:0]           x_mag;
    logic signed [21:0]    x_next;

    logic                  s3_vld_reg;
    logic signed [23:0]    y_reg;
    env_t                  s3_env_reg;
    logic signed [54:0]    y_prod;
    exp_side_t             e_side_in;

    logic                  e_vld;
    sum_t                  e_pow2;
    exp_side_t             e_side;

    logic                  s5_vld_reg;
    logic [35:0]           p_reg;
    logic [27:0]           a_reg;
    logic [25:0]           d_reg;
    logic signed [N_W-1:0] sh;
    logic [N_W-1:0]        neg_sh;
    logic [35:0]           p_next;
    logic signed [16:0]    kel_sum;

    logic                  s6_vld_reg;
    logic [45:0]           pp_lo_reg;
    logic [45:0]           pp_hi_reg;
    logic [25:0]           s6_d_reg;

    logic                  s7_vld_reg;
    logic [63:0]           num2_reg;
    logic [25:0]           s7_d_reg;

    logic                  d2_vld;
    logic [39:0]           d2_quot;

    logic                  done_reg;
    logic [OUT_W-1:0]      abs_reg;
    logic                  sat_reg;
    logic [40:0]           r_next;
    logic                  sat_next;

    assign busy = 1'b0;

    // Stage 1: magnitude of the Magnus numerator and the positive divisor.
    assign cmag = c_reg[C_W-1] ? C_W'(~c_reg) + C_W'(1) : C_W'(c_reg);
    assign den1_sum = 17'(c_reg) + MAGNUS_DEN;

    ahc_divider #(
        .NW(33),
        .DW(16),
        .QW(21),
        .SW($bits(div_side_t))
    ) u_div_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_vld_reg),
        .numer    (s1_num_reg),
        .denom    (s1_den_reg),
        .side_in  (s1_side_reg),
        .out_valid(d1_vld),
        .quot     (d1_quot),
        .rem      (d1_rem),
        .side_out (d1_side)
    );

    // Stage 2: floor division result for a negative numerator rounds away from zero.
    assign x_mag = 22'(d1_quot) + 22'(d1_side.neg && (d1_rem != 16'd0));
    assign x_next = d1_side.neg ? -$signed(x_mag) : $signed(x_mag);

    // Stage 3: exponent times log2(10), Q16.
    assign y_prod = 55'(x_reg) * 55'($signed({1'b0, LOG2_10_Q30}));

    assign e_side_in.n   = y_reg[23:16];
    assign e_side_in.env = s3_env_reg;

    ahc_exp2 #(
        .SW($bits(exp_side_t))
    ) u_exp2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s3_vld_reg),
        .frac     (y_reg[15:0]),
        .side_in  (e_side_in),
        .out_valid(e_vld),
        .pow2     (e_pow2),
        .side_out (e_side)
    );

    // Stage 5: scale 2^f to 10^x in Q24, and form both gas-law factors.
    assign sh = e_side.n - N_W'(6);
    assign neg_sh = N_W'(-sh);
    assign p_next = sh[N_W-1] ? (36'(e_pow2) >> neg_sh) : (36'(e_pow2) << sh[2:0]);
    assign kel_sum = 17'(e_side.env.c) + KELVIN_OFS;

    ahc_divider #(
        .NW(64),
        .DW(26),
        .QW(40),
        .SW(1)
    ) u_div_gas (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s7_vld_reg),
        .numer    (num2_reg),
        .denom    (s7_d_reg),
        .side_in  (1'b0),
        .out_valid(d2_vld),
        .quot     (d2_quot),
        .rem      (),
        .side_out ()
    );

    assign r_next = (41'(d2_quot) + RND_HALF) >> RND_SHIFT;
    assign sat_next = (r_next > 41'd65535);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
            s1_vld_reg <= in_vld_reg;
            s2_vld_reg <= d1_vld;
            s3_vld_reg <= s2_vld_reg;
            s5_vld_reg <= e_vld;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            done_reg   <= d2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg              <= rel_humidity;
        c_reg              <= temperature;
        s1_num_reg         <= 33'(cmag) * 33'(MAGNUS_NUM);
        s1_den_reg         <= den1_sum[15:0];
        s1_side_reg.neg    <= c_reg[C_W-1];
        s1_side_reg.env.h  <= h_reg;
        s1_side_reg.env.c  <= c_reg;
        x_reg              <= x_next;
        s2_env_reg         <= d1_side.env;
        y_reg              <= y_prod[53:30];
        s3_env_reg         <= s2_env_reg;
        p_reg              <= p_next;
        a_reg              <= 28'(e_side.env.h) * 28'(VP_SCALE);
        d_reg              <= 26'(kel_sum[15:0]) * 26'(GAS_SCALE);
        pp_lo_reg          <= 46'(a_reg) * 46'(p_reg[17:0]);
        pp_hi_reg          <= 46'(a_reg) * 46'(p_reg[35:18]);
        s6_d_reg           <= d_reg;
        num2_reg           <= 64'(pp_lo_reg) + (64'(pp_hi_reg) << 18);
        s7_d_reg           <= s6_d_reg;
        abs_reg            <= sat_next ? {OUT_W{1'b1}} : r_next[OUT_W-1:0];
        sat_reg            <= sat_next;
    end

    assign done         = done_reg;
    assign abs_humidity = abs_reg;
    assign saturated    = sat_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("transaction result missing after pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching transaction");

    a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (abs_humidity == {OUT_W{1'b1}}))
        else $error("saturated result not clamped to full scale");

endmodule
